// File: hw/rtl/imhq_pkg.sv
// Shared types, codes and helpers of the indexed min-heap queue.
package imhq_pkg;

    localparam int VERTEX_W     = 8;
    localparam int MAP_DEPTH    = 256;
    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam int SLOT1_W      = 17;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DECREASE = 2'd1,
        KIND_EXTRACT  = 2'd2,
        KIND_QUERY    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_lvl_en;

    function automatic logic [4:0] msb_of(input logic [SLOT1_W-1:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < SLOT1_W; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/imhq_level.sv
// One heap level cell: vertex and key storage for the slots of one tree level.
module imhq_level
    import imhq_pkg::*;
#(
    parameter int LEVEL    = 0,
    parameter int IDX_W    = 1,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  t_lvl_en             i_en,
    input  logic [IDX_W-1:0]    i_rd_idx_a,
    input  logic [IDX_W-1:0]    i_rd_idx_b,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  logic [VERTEX_W-1:0] i_wr_vertex,
    input  logic [KEY_BITS-1:0] i_wr_key,
    output logic [VERTEX_W-1:0] o_vertex_a,
    output logic [KEY_BITS-1:0] o_key_a,
    output logic [VERTEX_W-1:0] o_vertex_b,
    output logic [KEY_BITS-1:0] o_key_b
);

    localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
    localparam int DEPTH = 2 ** AW;

    logic [VERTEX_W-1:0] mem_v [DEPTH];
    logic [KEY_BITS-1:0] mem_k [DEPTH];
    logic [VERTEX_W-1:0] r_va, r_vb;
    logic [KEY_BITS-1:0] r_ka, r_kb;

    always_ff @(posedge i_clk) begin
        if (i_en.wr) begin
            mem_v[i_wr_idx[AW-1:0]] <= i_wr_vertex;
            mem_k[i_wr_idx[AW-1:0]] <= i_wr_key;
        end
        if (i_en.rd) begin
            r_va <= mem_v[i_rd_idx_a[AW-1:0]];
            r_ka <= mem_k[i_rd_idx_a[AW-1:0]];
            r_vb <= mem_v[i_rd_idx_b[AW-1:0]];
            r_kb <= mem_k[i_rd_idx_b[AW-1:0]];
        end
    end

    assign o_vertex_a = r_va;
    assign o_key_a    = r_ka;
    assign o_vertex_b = r_vb;
    assign o_key_b    = r_kb;

endmodule

// File: hw/rtl/imhq_vmap.sv
// Vertex to heap slot map with per-entry valid bits.
module imhq_vmap
    import imhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int SLOT_W   = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [VERTEX_W-1:0] i_rd_addr,
    output logic [SLOT_W-1:0]   o_rd_slot,
    input  logic                i_wr_en,
    input  logic [VERTEX_W-1:0] i_wr_addr,
    input  logic [SLOT_W-1:0]   i_wr_slot
);

    logic [SLOT_W-1:0]    mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_valid;
    logic [SLOT_W-1:0]    r_data;
    logic                 r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_slot;
        end
        if (i_rd_en) begin
            r_data <= mem[i_rd_addr];
            r_vld  <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_slot = r_vld ? r_data : SLOT_W'(CAPACITY);

endmodule

// File: hw/rtl/indexed_min_heap_queue_core.sv
// Top level of the indexed min-heap queue: sequencer over a row of heap level cells.
//
// channel | dir | handshake             | payload
// s       | in  | i_s_tvalid/o_s_tready | i_s_tuser kind, i_s_tdata vertex, key
// m       | out | o_m_tvalid/i_m_tready | o_m_tdata vertex, key, present, status
//
// Query and failed ops finish after the map lookup. Insert and decrease climb the
// tree; extract descends it, but not when it takes the last entry. Each level
// climbed or descended costs one registered read of a level cell and one
// compare-and-write.
// Reset (synchronous, active low) empties the heap at once; no clearing pass.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken.
module indexed_min_heap_queue_core
    import imhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] vertex, [39:8] key
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [7:0] out_vertex, [39:8] out_key, [40] present,
                                     // [42:41] status, [47:43] zero
);

    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int LV_W   = $clog2(LEVELS);
    localparam int IDX_W  = LEVELS - 1;
    localparam logic [SLOT_W-1:0] CAP_S = SLOT_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_MAP, S_UP, S_UPC, S_DKC, S_EX2, S_EX3, S_DN, S_DNC, S_DONE
    } t_state;

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [VERTEX_W-1:0] r_v, n_v;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [SLOT_W-1:0]   r_hole, n_hole;
    logic [VERTEX_W-1:0] r_mv_v, n_mv_v;
    logic [KEY_BITS-1:0] r_mv_k, n_mv_k;
    logic [SLOT_W-1:0]   r_count, n_count;
    logic [VERTEX_W-1:0] r_res_v, n_res_v;
    logic [KEY_BITS-1:0] r_res_k, n_res_k;
    logic                r_res_pr, n_res_pr;
    t_status             r_res_st, n_res_st;
    logic [LV_W-1:0]     r_rd_lvl;
    logic                r_o_valid;
    logic [VERTEX_W-1:0] r_o_v;
    logic [KEY_BITS-1:0] r_o_k;
    logic                r_o_pr;
    t_status             r_o_st;

    logic                rd_en, wr_en, map_rd, map_we;
    logic [SLOT_W-1:0]   rd_slot, wr_slot, map_wd, map_slot;
    logic [VERTEX_W-1:0] wr_v, map_wa;
    logic [KEY_BITS-1:0] wr_k;
    logic [LV_W-1:0]     rd_lvl, wr_lvl;
    logic [IDX_W-1:0]    rd_idx, wr_idx;
    logic [SLOT1_W-1:0]  rd_s1, wr_s1;
    logic [4:0]          rd_msb, wr_msb;
    logic [63:0]         in_k64, out_k64;
    logic                accept, present, sel_l, sel_r, right_ok;
    logic [SLOT_W:0]     left_w, right_w;
    logic [SLOT_W-1:0]   parent;
    logic [KEY_BITS-1:0] best_k;

    logic [VERTEX_W-1:0] cv_a [LEVELS];
    logic [KEY_BITS-1:0] ck_a [LEVELS];
    logic [VERTEX_W-1:0] cv_b [LEVELS];
    logic [KEY_BITS-1:0] ck_b [LEVELS];
    logic [VERTEX_W-1:0] rv_a, rv_b;
    logic [KEY_BITS-1:0] rk_a, rk_b;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_k64     = {32'b0, i_s_tdata[39:8]};

    assign rd_s1  = SLOT1_W'(rd_slot) + SLOT1_W'(1);
    assign rd_msb = msb_of(rd_s1);
    assign rd_lvl = LV_W'(rd_msb);
    assign rd_idx = IDX_W'(rd_s1 ^ (SLOT1_W'(1) << rd_msb));
    assign wr_s1  = SLOT1_W'(wr_slot) + SLOT1_W'(1);
    assign wr_msb = msb_of(wr_s1);
    assign wr_lvl = LV_W'(wr_msb);
    assign wr_idx = IDX_W'(wr_s1 ^ (SLOT1_W'(1) << wr_msb));

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        t_lvl_en en;
        assign en.rd = rd_en && (rd_lvl == LV_W'(l));
        assign en.wr = wr_en && (wr_lvl == LV_W'(l));
        imhq_level #(
            .LEVEL(l), .IDX_W(IDX_W), .KEY_BITS(KEY_BITS)
        ) u_level (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_rd_idx_a (rd_idx),
            .i_rd_idx_b (rd_idx + IDX_W'(1)),
            .i_wr_idx   (wr_idx),
            .i_wr_vertex(wr_v),
            .i_wr_key   (wr_k),
            .o_vertex_a (cv_a[l]),
            .o_key_a    (ck_a[l]),
            .o_vertex_b (cv_b[l]),
            .o_key_b    (ck_b[l])
        );
    end

    assign rv_a = cv_a[r_rd_lvl];
    assign rk_a = ck_a[r_rd_lvl];
    assign rv_b = cv_b[r_rd_lvl];
    assign rk_b = ck_b[r_rd_lvl];

    imhq_vmap #(
        .CAPACITY(CAPACITY), .SLOT_W(SLOT_W)
    ) u_vmap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (map_rd),
        .i_rd_addr(i_s_tdata[7:0]),
        .o_rd_slot(map_slot),
        .i_wr_en  (map_we),
        .i_wr_addr(map_wa),
        .i_wr_slot(map_wd)
    );

    assign map_rd   = accept;
    assign present  = map_slot < r_count;
    assign parent   = (r_hole - SLOT_W'(1)) >> 1;
    assign left_w   = {r_hole, 1'b1};
    assign right_w  = left_w + (SLOT_W + 1)'(1);
    assign right_ok = right_w < {1'b0, r_count};
    assign sel_l    = rk_a < r_mv_k;
    assign best_k   = sel_l ? rk_a : r_mv_k;
    assign sel_r    = right_ok && (rk_b < best_k);

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_v      = r_v;
        n_key    = r_key;
        n_hole   = r_hole;
        n_mv_v   = r_mv_v;
        n_mv_k   = r_mv_k;
        n_count  = r_count;
        n_res_v  = r_res_v;
        n_res_k  = r_res_k;
        n_res_pr = r_res_pr;
        n_res_st = r_res_st;
        rd_en    = 1'b0;
        rd_slot  = '0;
        wr_en    = 1'b0;
        wr_slot  = r_hole;
        wr_v     = r_mv_v;
        wr_k     = r_mv_k;
        map_we   = 1'b0;
        map_wa   = r_mv_v;
        map_wd   = r_hole;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = t_kind'(i_s_tuser);
                    n_v      = i_s_tdata[7:0];
                    n_key    = in_k64[KEY_BITS-1:0];
                    n_res_v  = '0;
                    n_res_k  = '0;
                    n_res_pr = 1'b0;
                    n_res_st = ST_OK;
                    n_state  = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_DONE;
                case (r_kind)
                    KIND_INSERT: begin
                        if (r_count >= CAP_S) begin
                            n_res_st = ST_FULL;
                        end else if (!present) begin
                            n_hole  = r_count;
                            n_count = r_count + SLOT_W'(1);
                            n_mv_v  = r_v;
                            n_mv_k  = r_key;
                            n_state = S_UP;
                        end
                    end
                    KIND_DECREASE: begin
                        if (present) begin
                            n_hole  = map_slot;
                            rd_en   = 1'b1;
                            rd_slot = map_slot;
                            n_state = S_DKC;
                        end
                    end
                    KIND_EXTRACT: begin
                        if (r_count == '0) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_slot = '0;
                            n_state = S_EX2;
                        end
                    end
                    default: begin
                        n_res_pr = present;
                    end
                endcase
            end
            S_DKC: begin
                if (r_key <= rk_a) begin
                    n_mv_v  = r_v;
                    n_mv_k  = r_key;
                    n_state = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP: begin
                if (r_hole == '0) begin
                    wr_en   = 1'b1;
                    map_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_slot = parent;
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                wr_en  = 1'b1;
                map_we = 1'b1;
                if (r_mv_k < rk_a) begin
                    wr_v    = rv_a;
                    wr_k    = rk_a;
                    map_wa  = rv_a;
                    n_hole  = parent;
                    n_state = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EX2: begin
                n_res_v = rv_a;
                n_res_k = rk_a;
                map_we  = 1'b1;
                map_wa  = rv_a;
                map_wd  = CAP_S;
                n_count = r_count - SLOT_W'(1);
                if (r_count == SLOT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_slot = r_count - SLOT_W'(1);
                    n_state = S_EX3;
                end
            end
            S_EX3: begin
                n_mv_v  = rv_a;
                n_mv_k  = rk_a;
                n_hole  = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (left_w >= {1'b0, r_count}) begin
                    wr_en   = 1'b1;
                    map_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_slot = left_w[SLOT_W-1:0];
                    n_state = S_DNC;
                end
            end
            S_DNC: begin
                wr_en  = 1'b1;
                map_we = 1'b1;
                if (sel_r) begin
                    wr_v    = rv_b;
                    wr_k    = rk_b;
                    map_wa  = rv_b;
                    n_hole  = right_w[SLOT_W-1:0];
                    n_state = S_DN;
                end else if (sel_l) begin
                    wr_v    = rv_a;
                    wr_k    = rk_a;
                    map_wa  = rv_a;
                    n_hole  = left_w[SLOT_W-1:0];
                    n_state = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && (!r_o_valid || i_m_tready)) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_v      <= n_v;
        r_key    <= n_key;
        r_hole   <= n_hole;
        r_mv_v   <= n_mv_v;
        r_mv_k   <= n_mv_k;
        r_res_v  <= n_res_v;
        r_res_k  <= n_res_k;
        r_res_pr <= n_res_pr;
        r_res_st <= n_res_st;
        if (rd_en) begin
            r_rd_lvl <= rd_lvl;
        end
        if (r_state == S_DONE && (!r_o_valid || i_m_tready)) begin
            r_o_v  <= r_res_v;
            r_o_k  <= r_res_k;
            r_o_pr <= r_res_pr;
            r_o_st <= r_res_st;
        end
    end

    assign out_k64    = 64'(r_o_k);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {5'b0, r_o_st, r_o_pr, out_k64[31:0], r_o_v};

endmodule

// File: hw/rtl/imhq_checker.sv
// Port-level checks of the indexed min-heap queue, bound to the top level.
module imhq_checker
    import imhq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[42:41] <= ST_FULL)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[42:41] != ST_OK |-> o_m_tdata[40:0] == 41'd0)
        else $error("failed operation carries data");

    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[40] |-> o_m_tdata[39:0] == 40'd0)
        else $error("query answer carries vertex or key");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transfer taken during work");

endmodule

bind indexed_min_heap_queue_core imhq_checker u_imhq_checker (.*);

// File: verif/tb_indexed_min_heap_queue_core.sv
// Testbench of the indexed min-heap queue core: stream stimulus checked against an own heap model.
module tb_indexed_min_heap_queue_core;
    timeunit 1ns;
    timeprecision 1ps;
    import imhq_pkg::*;

    localparam int CAP = 256;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;   // [7:0] vertex, [39:8] key
    logic [1:0]  i_s_tuser = '0;   // [1:0] kind
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // [7:0] vertex, [39:8] key, [40] present, [42:41] status

    indexed_min_heap_queue_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [1:0]  status;
        logic        present;
        logic [31:0] key;
        logic [7:0]  vertex;
    } t_result;

    logic [7:0]  heap_vtx [CAP];
    logic [31:0] heap_key [CAP];
    int          vtx_pos [256];
    int          heap_size;
    t_result     pending_results[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    bit          rx_hold = 0;
    int          hold_cycles = 0;
    bit          rx_fast = 0;

    function automatic void hp_place(int s, logic [7:0] v, logic [31:0] k);
        heap_vtx[s] = v;
        heap_key[s] = k;
        vtx_pos[v] = s;
    endfunction

    function automatic void hp_swap(int a, int b);
        logic [7:0]  va;
        logic [31:0] ka;
        va = heap_vtx[a];
        ka = heap_key[a];
        hp_place(a, heap_vtx[b], heap_key[b]);
        hp_place(b, va, ka);
    endfunction

    function automatic void hp_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(heap_key[i] < heap_key[p])) break;
            hp_swap(i, p);
            i = p;
        end
    endfunction

    function automatic void hp_down(int i);
        int b, l, r;
        forever begin
            b = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < heap_size && heap_key[l] < heap_key[b]) b = l;
            if (r < heap_size && heap_key[r] < heap_key[b]) b = r;
            if (b == i) break;
            hp_swap(i, b);
            i = b;
        end
    endfunction

    function automatic t_result heap_apply(t_kind k, logic [7:0] v, logic [31:0] key);
        t_result r;
        int s;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_INSERT: begin
                if (heap_size >= CAP) begin
                    r.status = ST_FULL;
                end else if (!(vtx_pos[v] < heap_size)) begin
                    s = heap_size;
                    heap_size++;
                    hp_place(s, v, key);
                    hp_up(s);
                end
            end
            KIND_DECREASE: begin
                if (vtx_pos[v] < heap_size) begin
                    s = vtx_pos[v];
                    if (key <= heap_key[s]) begin
                        heap_key[s] = key;
                        hp_up(s);
                    end
                end
            end
            KIND_EXTRACT: begin
                if (heap_size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.vertex = heap_vtx[0];
                    r.key = heap_key[0];
                    vtx_pos[heap_vtx[0]] = CAP;
                    heap_size--;
                    if (heap_size > 0) begin
                        hp_place(0, heap_vtx[heap_size], heap_key[heap_size]);
                        hp_down(0);
                    end
                end
            end
            default: r.present = (vtx_pos[v] < heap_size);
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_op(t_kind k, logic [7:0] v, logic [31:0] key, bit nogap = 0);
        int g;
        g = nogap ? 0 : gap_len();
        repeat (g + 1) @(negedge i_clk);
        pending_results.push_back(heap_apply(k, v, key));
        i_s_tuser <= k;
        i_s_tdata <= {key, v};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (rx_hold) begin
            i_m_tready <= 1'b0;
        end else if (rx_fast) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[42:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.vertex !== want.vertex || got.key !== want.key ||
                    got.present !== want.present || got.status !== want.status ||
                    o_m_tdata[47:43] !== 5'd0) begin
                    $display("%0t: expected v=%h k=%h p=%b s=%h, actual v=%h k=%h p=%b s=%h",
                             $time, want.vertex, want.key, want.present, want.status,
                             got.vertex, got.key, got.present, got.status);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(KIND_EXTRACT, 8'd0, 32'd0);
        send_op(KIND_QUERY, 8'd0, 32'd0);
        send_op(KIND_DECREASE, 8'd5, 32'd1);
        send_op(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 8'd0, 32'd0);
        send_op(KIND_INSERT, 8'hAA, 32'h5555_5555);
        send_op(KIND_INSERT, 8'h55, 32'hAAAA_AAAA);
        send_op(KIND_INSERT, 8'hAA, 32'd1);
        send_op(KIND_QUERY, 8'hFF, 32'd0);
        send_op(KIND_DECREASE, 8'h55, 32'hFFFF_FFFF);
        send_op(KIND_DECREASE, 8'h55, 32'hAAAA_AAAA);
        send_op(KIND_DECREASE, 8'hFF, 32'd0);
        send_op(KIND_EXTRACT, 8'd0, 32'd0);
        send_op(KIND_EXTRACT, 8'd0, 32'd0);
        send_op(KIND_QUERY, 8'd0, 32'd0);
        send_op(KIND_INSERT, 8'd0, 32'd7);
        send_op(KIND_QUERY, 8'd0, 32'd0);
        repeat (5) send_op(KIND_EXTRACT, 8'd0, 32'd0);
    endtask

    task automatic test_fill_full();
        for (int v = 0; v < 256; v++) send_op(KIND_INSERT, 8'(v), $urandom, 1);
        send_op(KIND_INSERT, 8'd3, 32'd1);
        send_op(KIND_QUERY, 8'hFF, 32'd0);
        for (int i = 0; i < 10; i++) send_op(KIND_DECREASE, 8'($urandom), $urandom_range(0, 9));
        for (int i = 0; i < 60; i++) send_op(KIND_EXTRACT, 8'd0, 32'd0, 1);
    endtask

    task automatic test_backpressure();
        rx_hold = 1;
        fork
            begin
                for (int i = 0; i < 12; i++) send_op(KIND_INSERT, 8'($urandom), rand_key(), 1);
            end
            begin
                hold_cycles = 0;
                while (hold_cycles < 150) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                rx_hold = 0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < 140; i++) begin
            rx_fast = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: send_op(KIND_INSERT, 8'($urandom_range(0, 40)), rand_key());
                3: send_op(KIND_INSERT, 8'($urandom), rand_key());
                4, 5: send_op(KIND_DECREASE, 8'($urandom_range(0, 40)), rand_key());
                6, 7: send_op(KIND_EXTRACT, 8'($urandom), $urandom);
                default: send_op(KIND_QUERY, 8'($urandom_range(0, 40)), $urandom);
            endcase
            if (i == 70) wait_drained();
        end
        rx_fast = 0;
    endtask

    initial begin
        for (int v = 0; v < 256; v++) vtx_pos[v] = CAP;
        heap_size = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_full();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (60) @(negedge i_clk);
        $display("sent %0d operations of all four kinds, checked %0d results", n_sent, n_checked);
        $display("covered empty and full heap, duplicates, stale decreases and backpressure");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/imhq_pkg.sv
hw/rtl/imhq_level.sv
hw/rtl/imhq_vmap.sv
hw/rtl/indexed_min_heap_queue_core.sv
hw/rtl/imhq_checker.sv
verif/tb_indexed_min_heap_queue_core.sv
